// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the gait scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/odgs_pkg.sv =====
// Shared types, widths, codes and helpers of the gait scheduler.
`timescale 1ns / 1ps
`default_nettype none
package odgs_pkg;

  // Field and register widths
  localparam int TICK_W     = 32;
  localparam int SEG_CFG_W  = 5;
  localparam int TPS_W      = 10;
  localparam int OFF_W      = 4;
  localparam int DUR_W      = 5;
  localparam int PER_W      = TPS_W + SEG_CFG_W;
  localparam int Q_FRAC     = 16;
  localparam int Q_W        = Q_FRAC + 1;
  localparam int ROW_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << Q_FRAC;

  // Divider: quotient bits resolved per cycle
  localparam int DIV_BITS   = 4;
  localparam int DIV_CYCLES = TICK_W / DIV_BITS;

  localparam int MAX_SEGMENTS_DEF = 16;

  // Register reset values
  localparam logic [SEG_CFG_W-1:0] SEGMENTS_RST = 5'd10;
  localparam logic [TPS_W-1:0]     TPS_RST      = 10'd30;
  localparam logic [OFF_W-1:0]     OFF0_RST     = 4'd0;
  localparam logic [OFF_W-1:0]     OFF1_RST     = 4'd5;
  localparam logic [DUR_W-1:0]     DUR0_RST     = 5'd5;
  localparam logic [DUR_W-1:0]     DUR1_RST     = 5'd5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENTS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TPS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF0     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF1     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DUR0     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DUR1     = 3'd5;

  typedef enum logic [2:0] {
    MUL_PERIOD,
    MUL_ST0,
    MUL_ST1,
    MUL_D0,
    MUL_D1
  } mul_sel_t;

  typedef enum logic [1:0] {
    DIV_POS,
    DIV_SEG,
    DIV_WIN
  } div_op_t;

  typedef enum logic [1:0] {
    WIN_ST0,
    WIN_ST1,
    WIN_SW0,
    WIN_SW1
  } win_sel_t;

  typedef struct packed {
    logic     load_item;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     sw_en;
    logic     div_start;
    logic     div_store;
    div_op_t  div_op;
    win_sel_t win_sel;
    logic     row_init;
    logic     row_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic row_last;
    logic out_free;
  } status_t;

  // Remainder of a 4-bit offset by a segment count, restoring, one bit a step
  function automatic logic [SEG_CFG_W-1:0] mod_small(input logic [OFF_W-1:0] a,
                                                     input logic [SEG_CFG_W-1:0] b);
    logic [SEG_CFG_W:0] r;
    r = '0;
    for (int k = OFF_W - 1; k >= 0; k--) begin
      r = {r[SEG_CFG_W-1:0], a[k]};
      if (r >= {1'b0, b}) begin
        r = r - {1'b0, b};
      end
    end
    return r[SEG_CFG_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/odgs_div.sv =====
// Iterative restoring divider, several quotient bits per cycle.
`timescale 1ns / 1ps
`default_nettype none
module odgs_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [odgs_pkg::TICK_W-1:0] dividend,
  input  logic [odgs_pkg::PER_W-1:0]  divisor,
  output logic                      done,
  output logic [odgs_pkg::TICK_W-1:0] quot,
  output logic [odgs_pkg::PER_W-1:0]  rem
);
  import odgs_pkg::*;

  localparam int CNT_W = $clog2(DIV_CYCLES);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [PER_W-1:0] dvs;
  logic [TICK_W-1:0] q_step;
  logic [PER_W-1:0]  r_step;

  // Resolve DIV_BITS quotient bits
  always_comb begin
    logic [PER_W:0] sh;
    sh = '0;
    q_step = quot;
    r_step = rem;
    for (int k = 0; k < DIV_BITS; k++) begin
      sh = {r_step, q_step[TICK_W-1]};
      q_step = {q_step[TICK_W-2:0], 1'b0};
      if (sh >= {1'b0, dvs}) begin
        sh = sh - {1'b0, dvs};
        q_step[0] = 1'b1;
      end
      r_step = sh[PER_W-1:0];
    end
  end

  // Load operands, then shift quotient bits in
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      quot <= q_step;
      rem  <= r_step;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/odgs_datapath.sv =====
// Datapath: registers, multiplier, divider, window math and row generation.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module odgs_datapath #(
  parameter int MAX_SEGMENTS = odgs_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [odgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [odgs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [odgs_pkg::TICK_W-1:0]     current_tick,
  input  odgs_pkg::cmd_t                cmd,
  output odgs_pkg::status_t             status,
  input  logic                          row_stall,
  output logic                          row_valid,
  output logic [odgs_pkg::ROW_W-1:0]      row_index,
  output logic                          stance_leg0,
  output logic                          stance_leg1,
  output logic                          last_row,
  output logic [odgs_pkg::ROW_W-1:0]      segment_now,
  output logic [odgs_pkg::Q_W-1:0]        stance_progress_leg0,
  output logic [odgs_pkg::Q_W-1:0]        stance_progress_leg1,
  output logic [odgs_pkg::Q_W-1:0]        swing_progress_leg0,
  output logic [odgs_pkg::Q_W-1:0]        swing_progress_leg1
);
  import odgs_pkg::*;

  localparam int SEG_LIM = (1 << SEG_CFG_W) - 1;
  localparam int NMAX    = (MAX_SEGMENTS < SEG_LIM) ? MAX_SEGMENTS : SEG_LIM;
  localparam int CNT_W   = $clog2(NMAX + 1);

  // (a - b) mod n for a, b below n
  function automatic logic [CNT_W-1:0] wrap_sub(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b,
                                                input logic [CNT_W-1:0] n);
    logic [CNT_W:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + {1'b0, n} - {1'b0, b};
    end
    return s[CNT_W-1:0];
  endfunction

  // (a + 1) mod n for a below n
  function automatic logic [CNT_W-1:0] wrap_inc(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] n);
    logic [CNT_W:0] s;
    s = {1'b0, a} + 1'b1;
    return (s == {1'b0, n}) ? '0 : s[CNT_W-1:0];
  endfunction

  // Configuration registers
  logic [SEG_CFG_W-1:0] cfg_segments;
  logic [TPS_W-1:0]     cfg_tps;
  logic [OFF_W-1:0]     cfg_off0;
  logic [OFF_W-1:0]     cfg_off1;
  logic [DUR_W-1:0]     cfg_dur0;
  logic [DUR_W-1:0]     cfg_dur1;

  // Per-item registers
  logic [TICK_W-1:0] tick_r;
  logic [CNT_W-1:0]  n_r;
  logic [TPS_W-1:0]  t_r;
  logic [CNT_W-1:0]  off0_r;
  logic [CNT_W-1:0]  off1_r;
  logic [CNT_W-1:0]  dur0_r;
  logic [CNT_W-1:0]  dur1_r;
  logic [PER_W-1:0]  period_r;
  logic [PER_W-1:0]  st0_r;
  logic [PER_W-1:0]  st1_r;
  logic [PER_W-1:0]  d0_r;
  logic [PER_W-1:0]  d1_r;
  logic [PER_W-1:0]  sw0_r;
  logic [PER_W-1:0]  sw1_r;
  logic [PER_W-1:0]  pos_r;
  logic [CNT_W-1:0]  seg_r;
  logic [Q_W-1:0]    stp0_r;
  logic [Q_W-1:0]    stp1_r;
  logic [Q_W-1:0]    swp0_r;
  logic [Q_W-1:0]    swp1_r;
  logic              win_skip_r;
  logic [CNT_W-1:0]  row_r;
  logic [CNT_W-1:0]  pr0_r;
  logic [CNT_W-1:0]  pr1_r;

  // Combinational helpers
  logic [CNT_W-1:0]     n_c;
  logic [CNT_W-1:0]     dur0_c;
  logic [CNT_W-1:0]     dur1_c;
  logic [SEG_CFG_W-1:0] mul_a;
  logic [PER_W-1:0]     prod;
  logic [PER_W:0]       sw0_sum;
  logic [PER_W:0]       sw1_sum;
  logic [PER_W-1:0]     win_start;
  logic [PER_W-1:0]     win_len;
  logic [PER_W:0]       win_p;
  logic                 win_skip;
  logic [TICK_W-1:0]    div_dividend;
  logic [PER_W-1:0]     div_divisor;
  logic                 div_done;
  logic [TICK_W-1:0]    div_quot;
  logic [PER_W-1:0]     div_rem;
  logic [Q_W-1:0]       win_val;
  logic [CNT_W-1:0]     seg_next;
  logic                 row_last_c;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_segments <= SEGMENTS_RST;
      cfg_tps      <= TPS_RST;
      cfg_off0     <= OFF0_RST;
      cfg_off1     <= OFF1_RST;
      cfg_dur0     <= DUR0_RST;
      cfg_dur1     <= DUR1_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SEGMENTS: cfg_segments <= cfg_data[SEG_CFG_W-1:0];
        CFG_TPS:      cfg_tps      <= cfg_data[TPS_W-1:0];
        CFG_OFF0:     cfg_off0     <= cfg_data[OFF_W-1:0];
        CFG_OFF1:     cfg_off1     <= cfg_data[OFF_W-1:0];
        CFG_DUR0:     cfg_dur0     <= cfg_data[DUR_W-1:0];
        CFG_DUR1:     cfg_dur1     <= cfg_data[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp segment count and durations
  always_comb begin
    if (cfg_segments == '0) begin
      n_c = CNT_W'(1);
    end else if (cfg_segments > SEG_CFG_W'(NMAX)) begin
      n_c = CNT_W'(NMAX);
    end else begin
      n_c = CNT_W'(cfg_segments);
    end
    dur0_c = (cfg_dur0 > DUR_W'(n_c)) ? n_c : CNT_W'(cfg_dur0);
    dur1_c = (cfg_dur1 > DUR_W'(n_c)) ? n_c : CNT_W'(cfg_dur1);
  end

  // Shared segment-count by ticks multiplier
  always_comb begin
    case (cmd.mul_sel)
      MUL_PERIOD: mul_a = SEG_CFG_W'(n_r);
      MUL_ST0:    mul_a = SEG_CFG_W'(off0_r);
      MUL_ST1:    mul_a = SEG_CFG_W'(off1_r);
      MUL_D0:     mul_a = SEG_CFG_W'(dur0_r);
      MUL_D1:     mul_a = SEG_CFG_W'(dur1_r);
      default:    mul_a = '0;
    endcase
  end
  assign prod = PER_W'(mul_a) * PER_W'(t_r);

  // Swing starts, wrapped past the period
  assign sw0_sum = {1'b0, st0_r} + {1'b0, d0_r};
  assign sw1_sum = {1'b0, st1_r} + {1'b0, d1_r};

  // Window position relative to its start
  always_comb begin
    case (cmd.win_sel)
      WIN_ST0: begin
        win_start = st0_r;
        win_len   = d0_r;
      end
      WIN_ST1: begin
        win_start = st1_r;
        win_len   = d1_r;
      end
      WIN_SW0: begin
        win_start = sw0_r;
        win_len   = period_r - d0_r;
      end
      WIN_SW1: begin
        win_start = sw1_r;
        win_len   = period_r - d1_r;
      end
      default: begin
        win_start = '0;
        win_len   = '0;
      end
    endcase
    if (pos_r >= win_start) begin
      win_p = {1'b0, pos_r} - {1'b0, win_start};
    end else begin
      win_p = {1'b0, pos_r} + {1'b0, period_r} - {1'b0, win_start};
    end
    win_skip = (win_len == '0) || (win_p > {1'b0, win_len});
  end

  // Divider operands
  always_comb begin
    case (cmd.div_op)
      DIV_POS: begin
        div_dividend = tick_r;
        div_divisor  = period_r;
      end
      DIV_SEG: begin
        div_dividend = TICK_W'(pos_r);
        div_divisor  = PER_W'(t_r);
      end
      DIV_WIN: begin
        div_dividend = TICK_W'({win_p[PER_W-1:0], {Q_FRAC{1'b0}}});
        div_divisor  = win_len;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  odgs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign win_val    = win_skip_r ? '0 : Q_W'(div_quot);
  assign seg_next   = wrap_inc(seg_r, n_r);
  assign row_last_c = (row_r == n_r - 1'b1);

  // Latch item, products, divider results and row walkers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      tick_r <= current_tick;
      n_r    <= n_c;
      t_r    <= (cfg_tps == '0) ? TPS_W'(1) : cfg_tps;
      off0_r <= CNT_W'(mod_small(cfg_off0, SEG_CFG_W'(n_c)));
      off1_r <= CNT_W'(mod_small(cfg_off1, SEG_CFG_W'(n_c)));
      dur0_r <= dur0_c;
      dur1_r <= dur1_c;
    end
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        MUL_PERIOD: period_r <= prod;
        MUL_ST0:    st0_r    <= prod;
        MUL_ST1:    st1_r    <= prod;
        MUL_D0:     d0_r     <= prod;
        MUL_D1:     d1_r     <= prod;
        default: ;
      endcase
    end
    if (cmd.sw_en) begin
      sw0_r <= (sw0_sum > {1'b0, period_r}) ? PER_W'(sw0_sum - {1'b0, period_r})
                                             : PER_W'(sw0_sum);
      sw1_r <= (sw1_sum > {1'b0, period_r}) ? PER_W'(sw1_sum - {1'b0, period_r})
                                             : PER_W'(sw1_sum);
    end
    if (cmd.div_start && cmd.div_op == DIV_WIN) begin
      win_skip_r <= win_skip;
    end
    if (cmd.div_store) begin
      case (cmd.div_op)
        DIV_POS: pos_r <= div_rem;
        DIV_SEG: seg_r <= CNT_W'(div_quot);
        DIV_WIN: begin
          case (cmd.win_sel)
            WIN_ST0: stp0_r <= win_val;
            WIN_ST1: stp1_r <= win_val;
            WIN_SW0: swp0_r <= win_val;
            WIN_SW1: swp1_r <= win_val;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    if (cmd.row_init) begin
      row_r <= '0;
      pr0_r <= wrap_sub(seg_next, off0_r, n_r);
      pr1_r <= wrap_sub(seg_next, off1_r, n_r);
    end else if (cmd.row_load) begin
      row_r <= row_r + 1'b1;
      pr0_r <= wrap_inc(pr0_r, n_r);
      pr1_r <= wrap_inc(pr1_r, n_r);
    end
  end

  // Output register: hold while stalled, drop after the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= 1'b0;
    end else if (cmd.row_load) begin
      row_valid <= 1'b1;
    end else if (!row_stall) begin
      row_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_load) begin
      row_index            <= ROW_W'(row_r);
      stance_leg0          <= (pr0_r < dur0_r);
      stance_leg1          <= (pr1_r < dur1_r);
      last_row             <= row_last_c;
      segment_now          <= ROW_W'(seg_r);
      stance_progress_leg0 <= stp0_r;
      stance_progress_leg1 <= stp1_r;
      swing_progress_leg0  <= swp0_r;
      swing_progress_leg1  <= swp1_r;
    end
  end

  assign status.div_done = div_done;
  assign status.row_last = row_last_c;
  assign status.out_free = !row_valid || !row_stall;

  `ASSERT_IMPLY(a_no_overwrite, clk, rst, cmd.row_load, !row_valid || !row_stall)
  `ASSERT_IMPLY(a_row_in_range, clk, rst, cmd.row_load, row_r < n_r)
  `ASSERT_IMPLY(a_progress_max, clk, rst, row_valid,
                stance_progress_leg0 <= Q_ONE && swing_progress_leg0 <= Q_ONE)

endmodule
`default_nettype wire

// ===== rtl/core/odgs_ctrl.sv =====
// Controller: sequences multiplies, divisions and row emission per tick.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module odgs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              tick_valid,
  output logic              tick_stall,
  input  odgs_pkg::status_t status,
  output odgs_pkg::cmd_t    cmd
);
  import odgs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_POS,
    S_POS_W,
    S_SEG,
    S_SEG_W,
    S_WIN,
    S_WIN_W,
    S_EMIT
  } state_t;

  state_t   state;
  mul_sel_t mul_sel;
  win_sel_t win_sel;

  assign tick_stall = (state != S_IDLE);

  // Decode commands from state
  always_comb begin
    cmd         = '0;
    cmd.mul_sel = mul_sel;
    cmd.win_sel = win_sel;
    cmd.div_op  = DIV_POS;
    case (state)
      S_IDLE:  cmd.load_item = tick_valid;
      S_MUL:   cmd.mul_en = 1'b1;
      S_POS: begin
        cmd.sw_en     = 1'b1;
        cmd.div_start = 1'b1;
      end
      S_POS_W: cmd.div_store = status.div_done;
      S_SEG: begin
        cmd.div_op    = DIV_SEG;
        cmd.div_start = 1'b1;
      end
      S_SEG_W: begin
        cmd.div_op    = DIV_SEG;
        cmd.div_store = status.div_done;
      end
      S_WIN: begin
        cmd.div_op    = DIV_WIN;
        cmd.div_start = 1'b1;
        cmd.row_init  = 1'b1;
      end
      S_WIN_W: begin
        cmd.div_op    = DIV_WIN;
        cmd.div_store = status.div_done;
      end
      S_EMIT:  cmd.row_load = status.out_free;
      default: ;
    endcase
  end

  // Advance the sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      mul_sel <= MUL_PERIOD;
      win_sel <= WIN_ST0;
    end else begin
      case (state)
        S_IDLE: begin
          if (tick_valid) begin
            state   <= S_MUL;
            mul_sel <= MUL_PERIOD;
          end
        end
        S_MUL: begin
          case (mul_sel)
            MUL_PERIOD: mul_sel <= MUL_ST0;
            MUL_ST0:    mul_sel <= MUL_ST1;
            MUL_ST1:    mul_sel <= MUL_D0;
            MUL_D0:     mul_sel <= MUL_D1;
            default:    state   <= S_POS;
          endcase
        end
        S_POS:   state <= S_POS_W;
        S_POS_W: if (status.div_done) state <= S_SEG;
        S_SEG:   state <= S_SEG_W;
        S_SEG_W: begin
          if (status.div_done) begin
            state   <= S_WIN;
            win_sel <= WIN_ST0;
          end
        end
        S_WIN:   state <= S_WIN_W;
        S_WIN_W: begin
          if (status.div_done) begin
            case (win_sel)
              WIN_ST0: win_sel <= WIN_ST1;
              WIN_ST1: win_sel <= WIN_SW0;
              WIN_SW0: win_sel <= WIN_SW1;
              default: win_sel <= WIN_ST0;
            endcase
            state <= (win_sel == WIN_SW1) ? S_EMIT : S_WIN;
          end
        end
        S_EMIT: begin
          if (status.out_free && status.row_last) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, cmd.load_item, tick_stall)
  `ASSERT_IMPLY(a_done_when_waiting, clk, rst, status.div_done,
                state == S_POS_W || state == S_SEG_W || state == S_WIN_W)

endmodule
`default_nettype wire

// ===== rtl/core/offset_duration_gait_scheduler.sv =====
// Top level of the two-leg offset/duration gait scheduler.
//
// Tick channel: current_tick with tick_valid/tick_stall; a beat moves when
// valid is high and stall is low. Row channel: one beat per horizon row with
// row_valid/row_stall, N rows per tick (N = clamped segment count), the last
// flagged by last_row. Progress fields and segment_now repeat on every row.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; always
// ready, write only while the block is idle.
// Sequence: after a tick is accepted, the multiplies (period, stance starts,
// durations) and six divisions on one shared divider (4 quotient bits a cycle)
// precede the rows, and one row leaves per cycle when unstalled.
// The block takes the next tick once the last row sits in the output register.
// A stalled row holds in the output register and row generation pauses.
// Reset (rst, synchronous) clears the sequencer and the output valid and
// loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module offset_duration_gait_scheduler #(
  parameter int MAX_SEGMENTS = odgs_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            tick_valid,
  output logic                            tick_stall,
  input  logic [odgs_pkg::TICK_W-1:0]     current_tick,
  output logic                            row_valid,
  input  logic                            row_stall,
  output logic [odgs_pkg::ROW_W-1:0]      row_index,
  output logic                            stance_leg0,
  output logic                            stance_leg1,
  output logic                            last_row,
  output logic [odgs_pkg::ROW_W-1:0]      segment_now,
  output logic [odgs_pkg::Q_W-1:0]        stance_progress_leg0,
  output logic [odgs_pkg::Q_W-1:0]        stance_progress_leg1,
  output logic [odgs_pkg::Q_W-1:0]        swing_progress_leg0,
  output logic [odgs_pkg::Q_W-1:0]        swing_progress_leg1,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [odgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [odgs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import odgs_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Registers take a write on any cycle
  assign cfg_ready = 1'b1;

  odgs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .status     (status),
    .cmd        (cmd)
  );

  odgs_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_datapath (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_valid            (cfg_valid && cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .current_tick         (current_tick),
    .cmd                  (cmd),
    .status               (status),
    .row_stall            (row_stall),
    .row_valid            (row_valid),
    .row_index            (row_index),
    .stance_leg0          (stance_leg0),
    .stance_leg1          (stance_leg1),
    .last_row             (last_row),
    .segment_now          (segment_now),
    .stance_progress_leg0 (stance_progress_leg0),
    .stance_progress_leg1 (stance_progress_leg1),
    .swing_progress_leg0  (swing_progress_leg0),
    .swing_progress_leg1  (swing_progress_leg1)
  );

endmodule
`default_nettype wire
